>>> hdl/sttr_pkg.sv
package sttr_pkg;

    // Store depth and scan bounds
    localparam int MAX_ENTRIES = 64;
    localparam int MAX_DIM     = 256;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int COL_W = 9;

    localparam logic [COL_W-1:0] NUM_COLS_RST = COL_W'(256);

    // One stored triplet
    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } sttr_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store;
        logic start;
        logic tally;
        logic idx_clr;
        logic idx_inc;
        logic col_inc;
        logic emit;
        logic run_end;
    } sttr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_end;
        logic col_end;
        logic hit;
        logic below;
        logic out_free;
        logic none_left;
    } sttr_sts_t;

endpackage

>>> hdl/sttr_ifs.sv
// Entry channel: one source triplet per item
interface sttr_entry_if;
    logic                               valid;
    logic                               ready;
    logic [sttr_pkg::POS_W-1:0]         entry_row;
    logic [sttr_pkg::POS_W-1:0]         entry_col;
    logic signed [sttr_pkg::VAL_W-1:0]  entry_value;
    logic                               last_entry;

    modport source (output valid, entry_row, entry_col, entry_value, last_entry,
                    input ready);
    modport sink   (input valid, entry_row, entry_col, entry_value, last_entry,
                    output ready);
endinterface

// Result channel: one transposed triplet per item
interface sttr_result_if;
    logic                               valid;
    logic                               ready;
    logic [sttr_pkg::POS_W-1:0]         out_row;
    logic [sttr_pkg::POS_W-1:0]         out_col;
    logic signed [sttr_pkg::VAL_W-1:0]  out_value;
    logic                               last_result;
    logic                               dropped;

    modport source (output valid, out_row, out_col, out_value, last_result, dropped,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, last_result, dropped,
                    output ready);
endinterface

// Configuration write channel
interface sttr_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sttr_pkg::COL_W-1:0] num_cols;

    modport source (output valid, num_cols, input ready);
    modport sink   (input valid, num_cols, output ready);
endinterface

>>> hdl/sttr_ctrl.sv
module sttr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  sttr_pkg::sttr_sts_t sts,
    output sttr_pkg::sttr_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_CHK,
        S_COL,
        S_SCAN_RD,
        S_SCAN_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CNT_RD;
                    end
                end
            end
            // tally pass: count entries inside the column bound
            S_CNT_RD:
            begin
                if (sts.idx_end)
                    state_next = S_COL;
                else
                    state_next = S_CNT_CHK;
            end
            S_CNT_CHK:
            begin
                cmd.tally   = sts.below;
                cmd.idx_inc = 1'b1;
                state_next  = S_CNT_RD;
            end
            // column head: stop when columns or results run out
            S_COL:
            begin
                if (sts.col_end || sts.none_left)
                begin
                    cmd.run_end = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.none_left)
                begin
                    cmd.run_end = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sts.idx_end)
                begin
                    cmd.col_inc = 1'b1;
                    state_next  = S_COL;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            // emit on a match once the output register frees up
            S_SCAN_CHK:
            begin
                if (!sts.hit)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/sttr_dp.sv
module sttr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sttr_pkg::POS_W-1:0]        entry_row,
    input  logic [sttr_pkg::POS_W-1:0]        entry_col,
    input  logic signed [sttr_pkg::VAL_W-1:0] entry_value,
    input  sttr_pkg::sttr_cmd_t               cmd,
    output sttr_pkg::sttr_sts_t               sts,
    sttr_cfg_if.sink                          cfg_ch,
    sttr_result_if.source                     result_ch
);

    localparam int CNT_W = sttr_pkg::CNT_W;
    localparam int IDX_W = sttr_pkg::IDX_W;
    localparam int COL_W = sttr_pkg::COL_W;

    // Triplet store, read data registered
    sttr_pkg::sttr_entry_t mem [sttr_pkg::MAX_ENTRIES];
    sttr_pkg::sttr_entry_t rd_data_reg;

    logic [COL_W-1:0] num_cols_reg;
    logic [CNT_W-1:0] entry_count_reg;
    logic             overflow_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic [COL_W-1:0] col_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] emit_cnt_reg;

    logic                              out_valid_reg;
    logic [sttr_pkg::POS_W-1:0]        out_row_reg;
    logic [sttr_pkg::POS_W-1:0]        out_col_reg;
    logic signed [sttr_pkg::VAL_W-1:0] out_value_reg;
    logic                              out_last_reg;
    logic                              out_drop_reg;

    logic [COL_W-1:0] limit;
    logic             store_full;
    logic [COL_W-1:0] rd_col_ext;

    // Column bound clipped to the largest dimension
    assign limit = (int'(num_cols_reg) > sttr_pkg::MAX_DIM)
                   ? COL_W'(sttr_pkg::MAX_DIM) : num_cols_reg;

    assign store_full = (entry_count_reg == CNT_W'(sttr_pkg::MAX_ENTRIES));
    assign rd_col_ext = {1'b0, rd_data_reg.col};

    // Status to controller
    assign sts.idx_end   = (scan_idx_reg == entry_count_reg);
    assign sts.col_end   = (col_reg == limit);
    assign sts.hit       = (rd_col_ext == col_reg);
    assign sts.below     = (rd_col_ext < limit);
    assign sts.out_free  = !out_valid_reg || result_ch.ready;
    assign sts.none_left = (emit_cnt_reg == total_reg);

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store && !store_full)
        begin
            mem[entry_count_reg[IDX_W-1:0]] <= '{row: entry_row, col: entry_col,
                                                value: entry_value};
        end
        rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
    end

    // Configuration register
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_cols_reg <= sttr_pkg::NUM_COLS_RST;
        else if (cfg_ch.valid)
            num_cols_reg <= cfg_ch.num_cols;
    end

    // Load count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (cmd.run_end)
        begin
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (cmd.store)
        begin
            if (store_full)
                overflow_reg <= 1'b1;
            else
                entry_count_reg <= entry_count_reg + CNT_W'(1);
        end
    end

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            col_reg      <= '0;
            total_reg    <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.start || cmd.idx_clr)
                scan_idx_reg <= '0;
            else if (cmd.idx_inc)
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);

            if (cmd.start)
                col_reg <= '0;
            else if (cmd.col_inc)
                col_reg <= col_reg + COL_W'(1);

            if (cmd.start)
                total_reg <= '0;
            else if (cmd.tally)
                total_reg <= total_reg + CNT_W'(1);

            if (cmd.start)
                emit_cnt_reg <= '0;
            else if (cmd.emit)
                emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg   <= rd_data_reg.col;
            out_col_reg   <= rd_data_reg.row;
            out_value_reg <= rd_data_reg.value;
            out_last_reg  <= ((emit_cnt_reg + CNT_W'(1)) == total_reg);
            out_drop_reg  <= overflow_reg;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.out_row     = out_row_reg;
    assign result_ch.out_col     = out_col_reg;
    assign result_ch.out_value   = out_value_reg;
    assign result_ch.last_result = out_last_reg;
    assign result_ch.dropped     = out_drop_reg;

endmodule

>>> hdl/sparse_triplet_transpose_core.sv
// Loading: one entry item per cycle, accepted while no transpose is running.
// After the last-marked item: a tally pass over the N stored entries, then
// per column a scan of the store and one closing state, plus time stalled on the
// result side; the run stops early once every counted result is out. The
// registered store read sets the scan rate.
// Reset: rst_n async active low clears control state; the store is not cleared.
module sparse_triplet_transpose_core (
    input  logic          clk,
    input  logic          rst_n,
    sttr_entry_if.sink    entry_ch,
    sttr_result_if.source result_ch,
    sttr_cfg_if.sink      cfg_ch
);

    sttr_pkg::sttr_cmd_t cmd;
    sttr_pkg::sttr_sts_t sts;

    sttr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry_ch.valid),
        .in_last  (entry_ch.last_entry),
        .in_ready (entry_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sttr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_row   (entry_ch.entry_row),
        .entry_col   (entry_ch.entry_col),
        .entry_value (entry_ch.entry_value),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_ch      (cfg_ch),
        .result_ch   (result_ch)
    );

endmodule
